// ===== rtl/cwsb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types and codes for the capacity weighted server balancer.
// Request and result word layouts, opcodes, status codes, register reset values.
// No dependencies.
package cwsb_pkg;

  localparam int REG_COUNT = 5;
  localparam int CFG_INDEX_W = 3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] slot_index;
  } request_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] server_index;
  } result_t;

  localparam logic [1:0] OP_NEW     = 2'd0;
  localparam logic [1:0] OP_RESUME  = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [2:0] ST_NEW      = 3'd0;
  localparam logic [2:0] ST_REUSED   = 3'd1;
  localparam logic [2:0] ST_RELEASED = 3'd2;
  localparam logic [2:0] ST_NOTHING  = 3'd3;
  localparam logic [2:0] ST_NO_ROOM  = 3'd4;

  localparam logic [2:0] UNASSIGNED = 3'd7;

  localparam logic [7:0] CAP_RESET [REG_COUNT] = '{8'd40, 8'd20, 8'd30, 8'd70, 8'd40};

endpackage
`default_nettype wire

// ===== rtl/capacity_weighted_server_balancer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Capacity weighted server balancer: smooth weighted round robin over servers.
// Slot map in a synchronous memory, occupancy and credits in registers.
// Depends on cwsb_pkg.
//
// Usage:
//   Request channel: a request word is taken at a clock edge with start high
//   and busy low. busy is high for the one cycle that follows.
//   Result channel: done pulses for one cycle with the result word, in the
//   cycle after busy. The receiver cannot stall it.
//   Configuration channel: cfg_ready is always high; cfg_index 0..4 selects a
//   server capacity, higher indexes are dropped. Write only while idle.
// Operation:
//   A new request is not taken while busy is high. The accepting edge reads
//   the slot map memory (registered read) and pre-adds weights to the
//   credits; the busy cycle picks the winner, and the edge that ends it
//   writes back map, occupancy and credits and registers the result.
// Reset:
//   rst clears map valid bits (every slot unassigned), occupancy and credits,
//   and loads the capacities with their reset values. No clearing pass.
module capacity_weighted_server_balancer
  import cwsb_pkg::*;
#(
  parameter int SLOT_COUNT   = 256,
  parameter int SERVER_COUNT = 5,
  parameter int CREDIT_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire request_t               request,
  output logic                        done,
  output result_t                     result,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]             cfg_data
);

  localparam int MAP_DEPTH = (SLOT_COUNT < 256) ? SLOT_COUNT : 256;
  localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam logic [12:0] SLOT_LIMIT = 13'(SLOT_COUNT);
  localparam logic [2:0]  SRV_LIMIT  = 3'(SERVER_COUNT);
  localparam int CW = CREDIT_WIDTH;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  function automatic logic signed [CW-1:0] sat_credit(input logic signed [CW:0] v);
    logic signed [CW-1:0] r;
    if (v[CW] != v[CW-1]) begin
      r = v[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  logic                 state;
  logic [7:0]           capacity [REG_COUNT];
  logic [8:0]           occupancy [SERVER_COUNT];
  logic signed [CW-1:0] credit [SERVER_COUNT];
  logic signed [CW-1:0] cand [SERVER_COUNT];
  request_t             req_q;
  logic [2:0]           map_mem [MAP_DEPTH];
  logic [MAP_DEPTH-1:0] map_vld;
  logic [2:0]           map_rd;
  logic                 vld_rd;

  logic                 accept;
  logic                 in_range;
  logic                 mapped;
  logic                 do_pick;
  logic                 pre_release;
  logic                 found;
  logic [2:0]           win;
  logic signed [CW-1:0] top_credit;
  logic signed [CW-1:0] win_credit;
  logic [10:0]          total;
  logic [8:0]           occ_rel [SERVER_COUNT];
  logic                 map_we;
  logic [2:0]           map_wdata;
  result_t              result_next;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state == S_EXEC);
  assign cfg_ready = 1'b1;

  always_comb begin
    in_range    = ({5'b0, req_q.slot_index} < SLOT_LIMIT);
    mapped      = vld_rd && (map_rd < SRV_LIMIT);
    do_pick     = in_range && ((req_q.opcode == OP_NEW) ||
                               ((req_q.opcode == OP_RESUME) && !mapped));
    pre_release = in_range && mapped &&
                  ((req_q.opcode == OP_RELEASE) || do_pick);
    total      = '0;
    found      = 1'b0;
    win        = '0;
    top_credit = '0;
    for (int i = 0; i < SERVER_COUNT; i++) begin
      total = total + {3'b0, capacity[i]};
      occ_rel[i] = occupancy[i];
      if (pre_release && (map_rd == 3'(i)) && (occupancy[i] != 9'd0)) begin
        occ_rel[i] = occupancy[i] - 9'd1;
      end
      if ((occ_rel[i] < {1'b0, capacity[i]}) && (!found || (cand[i] > top_credit))) begin
        found      = 1'b1;
        win        = 3'(i);
        top_credit = cand[i];
      end
    end
    win_credit = sat_credit($signed({top_credit[CW-1], top_credit}) -
                            $signed({{(CW-10){1'b0}}, total}));

    map_we    = pre_release || (do_pick && found);
    map_wdata = (do_pick && found) ? win : UNASSIGNED;

    result_next.status       = ST_NOTHING;
    result_next.server_index = '0;
    case (req_q.opcode)
      OP_NEW, OP_RESUME: begin
        if (!in_range) begin
          result_next.status = ST_NO_ROOM;
        end else if ((req_q.opcode == OP_RESUME) && mapped) begin
          result_next.status       = ST_REUSED;
          result_next.server_index = map_rd;
        end else if (found) begin
          result_next.status       = ST_NEW;
          result_next.server_index = win;
        end else begin
          result_next.status = ST_NO_ROOM;
        end
      end
      OP_RELEASE: begin
        if (pre_release) begin
          result_next.status       = ST_RELEASED;
          result_next.server_index = map_rd;
        end
      end
      default: begin
        result_next.status = ST_NOTHING;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      map_rd <= map_mem[request.slot_index[MAP_AW-1:0]];
      req_q  <= request;
      for (int i = 0; i < SERVER_COUNT; i++) begin
        cand[i] <= sat_credit($signed({credit[i][CW-1], credit[i]}) +
                              $signed({{(CW-7){1'b0}}, capacity[i]}));
      end
    end
    if ((state == S_EXEC) && map_we) begin
      map_mem[req_q.slot_index[MAP_AW-1:0]] <= map_wdata;
    end
    result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      map_vld <= '0;
      vld_rd  <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) begin
        capacity[i] <= CAP_RESET[i];
      end
      for (int i = 0; i < SERVER_COUNT; i++) begin
        occupancy[i] <= '0;
        credit[i]    <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        for (int i = 0; i < REG_COUNT; i++) begin
          if (cfg_index == CFG_INDEX_W'(i)) begin
            capacity[i] <= cfg_data;
          end
        end
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            vld_rd <= map_vld[request.slot_index[MAP_AW-1:0]];
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (map_we) begin
            map_vld[req_q.slot_index[MAP_AW-1:0]] <= 1'b1;
          end
          for (int i = 0; i < SERVER_COUNT; i++) begin
            occupancy[i] <= occ_rel[i];
            if (do_pick && found && (win == 3'(i))) begin
              occupancy[i] <= occ_rel[i] + 9'd1;
            end
            if (do_pick) begin
              credit[i] <= (found && (win == 3'(i))) ? win_credit : cand[i];
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in flight");

  a_server_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.server_index < SRV_LIMIT))
    else $error("result names a server beyond the server count");

  a_idle_server_zero: assert property (@(posedge clk) disable iff (rst)
    done && ((result.status == ST_NOTHING) || (result.status == ST_NO_ROOM))
      |-> (result.server_index == 3'd0))
    else $error("server index not zero on a failed request");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy && done)
    else $error("execute cycle did not retire in one cycle");
`endif

endmodule
`default_nettype wire
